[rtl/core/are_pkg.sv]
// ----------------------------------------------------------------------------
// are_pkg : shared types, constants and helpers for the adaptive Rice encoder
// Widths of the per-channel state, operation and kind codes, the zigzag map
// and the Rice width calculation.
// ----------------------------------------------------------------------------
package are_pkg;

  // Channel and sample geometry
  localparam int NUM_CH      = 8;
  localparam int CH_W        = 3;
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 28;
  localparam int MEAN_W      = 24;
  localparam int FRAC_W      = 8;
  localparam int KW          = 5;

  // Divisor range for the initial mean
  localparam int MAX_SAMPLES = 4096;
  localparam int DIV_W       = 13;
  localparam int CNT_W       = $clog2(SUM_W);

  // Configuration registers
  localparam int CNT_CFG_W   = 13;
  localparam int CHU_CFG_W   = 4;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam logic REG_SAMPLE_COUNT = 1'b0;
  localparam logic REG_CH_IN_USE    = 1'b1;
  localparam logic [CNT_CFG_W-1:0] SAMPLE_COUNT_RST = CNT_CFG_W'(4096);
  localparam logic [CHU_CFG_W-1:0] CH_IN_USE_RST    = CHU_CFG_W'(2);

  // Mean update coefficients: (A*m + B*(u<<8) + RND) >> SHR
  localparam int MEAN_A   = 119;
  localparam int MEAN_B   = 9;
  localparam int MEAN_RND = 1 << 6;
  localparam int MEAN_SHR = 7;
  localparam int ACC_W    = 32;

  // Item operation codes
  typedef logic [1:0] op_t;
  localparam op_t OP_ACCUM  = 2'd0;
  localparam op_t OP_FINISH = 2'd1;
  localparam op_t OP_ENCODE = 2'd2;

  // Result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_RICE   = 1'b1;
  localparam logic [KW-1:0] HEADER_BITS = KW'(16);

  typedef logic [SAMPLE_W-1:0] uval_t;

  // Zigzag map: 2s for s >= 0, -2s-1 for s < 0
  function automatic uval_t zigzag(input logic signed [SAMPLE_W-1:0] s);
    zigzag = {s[SAMPLE_W-2:0], 1'b0} ^ {SAMPLE_W{s[SAMPLE_W-1]}};
  endfunction

  // Rice width k = ceil(log2(max(r,1))), r = ((m>>1) + half) >> FRAC_W
  function automatic logic [KW-1:0] rice_k(input logic [MEAN_W-1:0] m);
    logic [MEAN_W-1:0] rsum;
    logic [SAMPLE_W-1:0] r;
    logic [SAMPLE_W-1:0] rm1;
    logic [KW-1:0] k;
    rsum = MEAN_W'(m >> 1) + MEAN_W'(1 << (FRAC_W - 1));
    r    = rsum[MEAN_W-1:FRAC_W];
    rm1  = r - SAMPLE_W'(1);
    k    = '0;
    if (r > SAMPLE_W'(1)) begin
      for (int i = 0; i < SAMPLE_W; i++) begin
        if (rm1[i]) k = KW'(i + 1);
      end
    end
    rice_k = k;
  endfunction

endpackage

[rtl/core/adaptive_rice_encoder_unit.sv]
// ----------------------------------------------------------------------------
// adaptive_rice_encoder_unit : per-channel adaptive Rice encoder
// Channel sums and running means live in two small RAMs; each item reads its
// channel's entry, updates it and writes it back.
// ----------------------------------------------------------------------------
// The block takes one item at a time and takes no new item until the last
// one is written back. An accumulate or encode item passes through accept,
// RAM read, and update and write-back. A finish item also runs the channel
// sum through the bit-serial divider, 28 steps and a done flag, before its
// write-back. An item for an inactive channel, or with an unknown operation,
// is taken and dropped. Results sit in an output register, so a result may
// wait on the output while the next item is taken; an item that produces a
// result stalls in its write-back step only while the previous result is
// still unclaimed. State reads as zero after reset; no clearing pass.
// ----------------------------------------------------------------------------
module adaptive_rice_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic [4:0]  in_tuser,   // [1:0] operation, [4:2] channel
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] zero_run, [31:16] payload,
                                  // [36:32] payload_bits, [39:37] zero
  output logic        out_tuser,  // [0] code_kind
  // configuration
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [are_pkg::APB_AW-1:0]       cfg_paddr,
  input  logic [are_pkg::APB_DW-1:0]       cfg_pwdata,
  output logic [are_pkg::APB_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready
);
  import are_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0]           state_r, state_nxt;
  op_t                  op_r;
  logic [CH_W-1:0]      ch_r;
  uval_t                u_r;
  logic [CNT_CFG_W-1:0] sample_count_r;
  logic [CHU_CFG_W-1:0] ch_in_use_r;
  logic [NUM_CH-1:0]    sum_vld_r, sum_vld_nxt;
  logic [NUM_CH-1:0]    mean_vld_r, mean_vld_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r;
  logic [SAMPLE_W-1:0]  out_run_r, out_pay_r;
  logic [KW-1:0]        out_bits_r;
  logic                 out_load;

  // Input decode
  op_t                  in_op;
  logic [CH_W-1:0]      in_ch;
  logic                 in_accept;
  logic                 in_active;

  assign in_op     = in_tuser[1:0];
  assign in_ch     = in_tuser[4:2];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_active = ({1'b0, in_ch} < ch_in_use_r) &&
                     (in_op == OP_ACCUM || in_op == OP_FINISH || in_op == OP_ENCODE);

  // State RAMs
  logic                 sum_we, mean_we;
  logic [SUM_W-1:0]     sum_wdata, sum_q, sum_val;
  logic [MEAN_W-1:0]    mean_wdata, mean_q, mean_val;
  logic                 rd_en;

  assign rd_en = in_accept && in_active;

  are_ram #(.WIDTH(SUM_W), .DEPTH(NUM_CH)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (ch_r),
    .wdata (sum_wdata),
    .re    (rd_en),
    .raddr (in_ch),
    .rdata (sum_q)
  );

  are_ram #(.WIDTH(MEAN_W), .DEPTH(NUM_CH)) u_mean_ram (
    .clk   (clk),
    .we    (mean_we),
    .waddr (ch_r),
    .wdata (mean_wdata),
    .re    (rd_en),
    .raddr (in_ch),
    .rdata (mean_q)
  );

  // Entries never written read as zero
  assign sum_val  = sum_vld_r[ch_r]  ? sum_q  : '0;
  assign mean_val = mean_vld_r[ch_r] ? mean_q : '0;

  // Divider for the initial mean, divisor clamped to 1..MAX_SAMPLES
  logic                 div_start, div_done;
  logic [SUM_W-1:0]     div_quot;
  logic [DIV_W-1:0]     divisor;
  logic [SAMPLE_W-1:0]  hdr_mean;

  always_comb begin
    if (sample_count_r == '0) begin
      divisor = DIV_W'(1);
    end else if (sample_count_r > CNT_CFG_W'(MAX_SAMPLES)) begin
      divisor = DIV_W'(MAX_SAMPLES);
    end else begin
      divisor = DIV_W'(sample_count_r);
    end
  end

  assign div_start = (state_r == S_READ) && (op_r == OP_FINISH);

  are_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_val),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign hdr_mean = (|div_quot[SUM_W-1:SAMPLE_W]) ? '1 : div_quot[SAMPLE_W-1:0];

  // Rice code and mean update for an encode item, sum update for an accumulate item
  logic [KW-1:0]        k;
  logic [SAMPLE_W-1:0]  rice_mask;
  logic [ACC_W-1:0]     mean_acc;
  logic [SUM_W-1:0]     sum_add;

  assign k         = rice_k(mean_val);
  assign rice_mask = ~(SAMPLE_W'('1) << k);
  assign mean_acc  = ACC_W'(mean_val) * ACC_W'(MEAN_A)
                   + ACC_W'({u_r, {FRAC_W{1'b0}}}) * ACC_W'(MEAN_B)
                   + ACC_W'(MEAN_RND);
  assign sum_add   = sum_val + SUM_W'(u_r);

  // Sequencer and write-back
  logic exec_go;

  assign exec_go = (state_r == S_EXEC) &&
                   ((op_r == OP_ACCUM) || !out_valid_r || out_tready);

  always_comb begin
    state_nxt    = state_r;
    sum_we       = 1'b0;
    mean_we      = 1'b0;
    sum_wdata    = sum_add;
    mean_wdata   = mean_acc[MEAN_SHR +: MEAN_W];
    out_load     = 1'b0;
    sum_vld_nxt  = sum_vld_r;
    mean_vld_nxt = mean_vld_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && in_active) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = (op_r == OP_FINISH) ? S_DIV : S_EXEC;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
          case (op_r)
            OP_ACCUM: begin
              sum_we            = 1'b1;
              sum_vld_nxt[ch_r] = 1'b1;
            end
            OP_FINISH: begin
              sum_we             = 1'b1;
              sum_wdata          = '0;
              mean_we            = 1'b1;
              mean_wdata         = {hdr_mean, {FRAC_W{1'b0}}};
              sum_vld_nxt[ch_r]  = 1'b1;
              mean_vld_nxt[ch_r] = 1'b1;
              out_load           = 1'b1;
            end
            default: begin
              mean_we            = 1'b1;
              mean_vld_nxt[ch_r] = 1'b1;
              out_load           = 1'b1;
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (out_load)   out_valid_nxt = 1'b1;
  end

  // Configuration writes
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SAMPLE_COUNT: cfg_prdata = APB_DW'(sample_count_r);
      REG_CH_IN_USE:    cfg_prdata = APB_DW'(ch_in_use_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sum_vld_r      <= '0;
      mean_vld_r     <= '0;
      out_valid_r    <= 1'b0;
      sample_count_r <= SAMPLE_COUNT_RST;
      ch_in_use_r    <= CH_IN_USE_RST;
    end else begin
      state_r     <= state_nxt;
      sum_vld_r   <= sum_vld_nxt;
      mean_vld_r  <= mean_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_SAMPLE_COUNT) begin
          sample_count_r <= cfg_pwdata[CNT_CFG_W-1:0];
        end else begin
          ch_in_use_r <= cfg_pwdata[CHU_CFG_W-1:0];
        end
      end
    end
  end

  // Item and result payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r <= in_op;
      ch_r <= in_ch;
      u_r  <= zigzag(in_tdata);
    end
    if (out_load) begin
      if (op_r == OP_FINISH) begin
        out_kind_r <= KIND_HEADER;
        out_run_r  <= '0;
        out_pay_r  <= hdr_mean;
        out_bits_r <= HEADER_BITS;
      end else begin
        out_kind_r <= KIND_RICE;
        out_run_r  <= SAMPLE_W'(u_r >> k);
        out_pay_r  <= u_r & rice_mask;
        out_bits_r <= k;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {3'b000, out_bits_r, out_pay_r, out_run_r};

endmodule

[rtl/core/are_ram.sv]
// ----------------------------------------------------------------------------
// are_ram : generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module are_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/are_divider.sv]
// ----------------------------------------------------------------------------
// are_divider : restoring divider for the initial channel mean
// Divides the 28-bit channel sum by the 13-bit sample count, one quotient bit
// per cycle. done pulses for one cycle; the quotient then holds until the
// next start.
// ----------------------------------------------------------------------------
module are_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [are_pkg::SUM_W-1:0] dividend,
  input  logic [are_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [are_pkg::SUM_W-1:0] quotient
);
  import are_pkg::*;

  logic [SUM_W-1:0] quot_r, quot_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;

  // One restoring step: shift in the next dividend bit, try to subtract
  assign rem_sh  = {rem_r, quot_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(SUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt  = rem_sub[DIV_W-1:0];
        quot_nxt = {quot_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[DIV_W-1:0];
        quot_nxt = {quot_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule
